>>> rtl/rchs_pkg.sv
// ----------------------------------------------------------------------------
// rchs_pkg: shared types and constants
// Entry kinds, request ops, scene entry layout, divider width, saturation.
// ----------------------------------------------------------------------------
package rchs_pkg;

    localparam logic [2:0] KIND_EMPTY  = 3'd0;
    localparam logic [2:0] KIND_CAMERA = 3'd1;
    localparam logic [2:0] KIND_SPHERE = 3'd2;
    localparam logic [2:0] KIND_PLANE  = 3'd3;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RAY  = 1'b1;

    // signed dividend width: (|h| + sqrt) * 2^16 stays below 2^50
    localparam int DIV_W = 51;
    // radicand width of the square root unit
    localparam int SQ_W  = 64;

    localparam logic signed [65:0] S32_MAX_W = 66'sd2147483647;
    localparam logic signed [65:0] S32_MIN_W = -66'sd2147483648;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
        logic signed [31:0] sc;
    } t_entry;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX_W) begin
            r = 32'sh7FFFFFFF;
        end else if (v < S32_MIN_W) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/rchs_sqrt.sv
// ----------------------------------------------------------------------------
// rchs_sqrt: iterative integer square root
// floor(sqrt(v)) of a 64-bit radicand, one result bit per cycle.
// ----------------------------------------------------------------------------
module rchs_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rchs_pkg::SQ_W-1:0]   i_val,
    output logic                        o_done,
    output logic [31:0]                 o_root
);

    localparam int ITER = rchs_pkg::SQ_W / 2;
    localparam int CW   = $clog2(ITER);

    logic                      r_busy;
    logic                      r_done;
    logic [CW-1:0]             r_cnt;
    logic [rchs_pkg::SQ_W-1:0] r_v;
    logic [rchs_pkg::SQ_W-1:0] r_res;
    logic [rchs_pkg::SQ_W-1:0] r_bit;
    logic [rchs_pkg::SQ_W-1:0] w_sum;

    assign w_sum  = r_res + r_bit;
    assign o_done = r_done;
    assign o_root = r_res[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(ITER - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_val;
            r_res <= '0;
            r_bit <= {2'b01, {(rchs_pkg::SQ_W - 2){1'b0}}};
        end else if (r_busy) begin
            if (r_v >= w_sum) begin
                r_v   <= r_v - w_sum;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

endmodule

>>> rtl/rchs_div.sv
// ----------------------------------------------------------------------------
// rchs_div: iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle; truncates
// toward zero.
// ----------------------------------------------------------------------------
module rchs_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [rchs_pkg::DIV_W-1:0]  i_dividend,
    input  logic signed [31:0]                 i_divisor,
    output logic                               o_done,
    output logic signed [rchs_pkg::DIV_W-1:0]  o_quot
);

    localparam int DW = rchs_pkg::DIV_W;
    localparam int CW = $clog2(DW);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [31:0]       r_rem;
    logic [DW-1:0]     r_quo;
    logic [31:0]       r_dvs;
    logic              r_neg;
    logic [32:0]       w_sh;
    logic              w_ge;
    logic [DW-1:0]     w_mag_dvd;
    logic [31:0]       w_mag_dvs;

    assign w_mag_dvd = i_dividend[DW-1] ? DW'(-i_dividend) : DW'(i_dividend);
    assign w_mag_dvs = i_divisor[31] ? 32'(-i_divisor) : 32'(i_divisor);
    assign w_sh      = {r_rem, r_quo[DW-1]};
    assign w_ge      = (w_sh >= {1'b0, r_dvs});
    assign o_done    = r_done;
    assign o_quot    = r_neg ? -$signed(r_quo) : $signed(r_quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= w_mag_dvd;
            r_dvs <= w_mag_dvs;
            r_neg <= i_dividend[DW-1] ^ i_divisor[31];
        end else if (r_busy) begin
            r_rem <= w_ge ? 32'(w_sh - {1'b0, r_dvs}) : w_sh[31:0];
            r_quo <= {r_quo[DW-2:0], w_ge};
        end
    end

endmodule

>>> rtl/ray_closest_hit_search_unit.sv
// ----------------------------------------------------------------------------
// ray_closest_hit_search_unit: closest sphere/plane hit over a scene table
// Load requests write one scene slot; ray requests walk the table and report
// the nearest positive hit distance with its slot and kind.
// ----------------------------------------------------------------------------
// Load: the slot is written on the request edge; busy stays low. Ray: each
//   walked slot is skipped, missed early (plane or sphere), plane hit tested or
//   sphere hit tested (far root retried when needed), using the shared 32x32 multiplier,
//   the 32-step square root and the 51-step divider.
// Throughput: one ray at a time; busy high until o_valid. Reset: synchronous
//   active-low i_rst_n clears the sequencer and slot valid bits; no stall.
// ----------------------------------------------------------------------------
module ray_closest_hit_search_unit #(
    parameter int MAX_ENTRIES = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_op,
    input  logic [6:0]         i_slot,
    input  logic [2:0]         i_kind,
    input  logic signed [31:0] i_px,
    input  logic signed [31:0] i_py,
    input  logic signed [31:0] i_pz,
    input  logic signed [31:0] i_qx,
    input  logic signed [31:0] i_qy,
    input  logic signed [31:0] i_qz,
    input  logic signed [31:0] i_scalar,
    input  logic [6:0]         i_exclude_slot,
    input  logic               i_exclude_valid,
    output logic               o_valid,
    output logic               o_hit,
    output logic signed [31:0] o_t_value,
    output logic [6:0]         o_hit_slot,
    output logic [2:0]         o_hit_kind
);

    localparam int          IW    = $clog2(MAX_ENTRIES);
    localparam logic [10:0] MAX_W = 11'(MAX_ENTRIES);

    // multiply/accumulate step numbers where a result is complete
    localparam logic [3:0] STP_A    = 4'd2;   // sphere: d.d
    localparam logic [3:0] STP_H    = 4'd5;   // sphere: d.e
    localparam logic [3:0] STP_C    = 4'd9;   // sphere: e.e - r^2
    localparam logic [3:0] STP_SPH  = 4'd11;  // sphere: discriminant
    localparam logic [3:0] STP_NUM  = 4'd2;   // plane: n.o + D
    localparam logic [3:0] STP_PLN  = 4'd5;   // plane: n.d

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_EXRD   = 10'b00_0000_0010,
        S_EXLAT  = 10'b00_0000_0100,
        S_RD     = 10'b00_0000_1000,
        S_CHK    = 10'b00_0001_0000,
        S_MAC    = 10'b00_0010_0000,
        S_SQRT   = 10'b00_0100_0000,
        S_DSTART = 10'b00_1000_0000,
        S_DIV    = 10'b01_0000_0000,
        S_DONE   = 10'b10_0000_0000
    } t_state;

    // ---------------- scene table ----------------
    rchs_pkg::t_entry   mem_ent [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] r_vld;
    rchs_pkg::t_entry   r_rd_ent;
    logic               r_rd_vld;
    logic [2:0]         w_k;

    logic               w_req;
    logic               w_wr;
    logic [10:0]        w_slot_ext;
    logic [10:0]        w_ex_ext;
    logic [IW-1:0]      w_waddr;
    logic [IW-1:0]      w_ra;
    rchs_pkg::t_entry   w_wdata;

    // ---------------- sequencer state ----------------
    t_state             r_state;
    logic [IW-1:0]      r_idx;
    logic               r_use_ex;
    logic [IW-1:0]      r_ex_idx;
    logic [2:0]         r_ex_kind;
    logic signed [31:0] r_ex_px, r_ex_py, r_ex_pz;
    logic signed [31:0] r_rox, r_roy, r_roz;
    logic signed [31:0] r_rdx, r_rdy, r_rdz;
    logic signed [31:0] r_e0, r_e1, r_e2;
    logic signed [31:0] r_a, r_h, r_c;   // plane: r_h = numerator, r_c = denominator
    logic [31:0]        r_s;
    logic               r_is_sph;
    logic               r_retry;
    logic [3:0]         r_step;
    logic               r_ph;
    logic signed [63:0] r_prod;
    logic signed [65:0] r_acc;
    logic               r_found;
    logic signed [31:0] r_best_t;
    logic [IW-1:0]      r_best_slot;
    logic [2:0]         r_best_kind;

    // ---------------- datapath wires ----------------
    logic signed [31:0] w_ma, w_mb;
    logic               w_first, w_neg, w_full, w_last;
    logic signed [65:0] w_term;
    logic signed [65:0] w_acc_new;
    logic signed [31:0] w_sat_acc;
    logic               w_sph_miss;
    logic               w_at_end;
    logic               w_ex_match;

    logic               w_sq_start;
    logic               w_sq_done;
    logic [31:0]        w_sq_root;
    logic               w_dv_start;
    logic               w_dv_done;
    logic signed [rchs_pkg::DIV_W-1:0] w_dvd;
    logic signed [rchs_pkg::DIV_W-1:0] w_quot;
    logic signed [31:0] w_dvs;
    logic signed [34:0] w_nh;
    logic signed [34:0] w_s35;
    logic signed [34:0] w_num1;
    logic signed [31:0] w_t;
    logic               w_take;

    assign busy = (r_state != S_IDLE);

    // ---------------- request decode and table write ----------------
    assign w_req      = start && !busy;
    assign w_slot_ext = 11'(i_slot);
    assign w_ex_ext   = 11'(i_exclude_slot);
    assign w_waddr    = w_slot_ext[IW-1:0];
    assign w_wr       = w_req && (i_op == rchs_pkg::OP_LOAD) && (w_slot_ext < MAX_W);
    assign w_ra       = (r_state == S_EXRD) ? r_ex_idx : r_idx;

    always_comb begin
        w_wdata.kind = i_kind;
        w_wdata.px   = i_px;
        w_wdata.py   = i_py;
        w_wdata.pz   = i_pz;
        w_wdata.nx   = i_qx;
        w_wdata.ny   = i_qy;
        w_wdata.nz   = i_qz;
        w_wdata.sc   = i_scalar;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            mem_ent[w_waddr] <= w_wdata;
        end
        r_rd_ent <= mem_ent[w_ra];
        r_rd_vld <= r_vld[w_ra];
    end

    // a slot never written reads as empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_wr) begin
            r_vld[w_waddr] <= 1'b1;
        end
    end

    assign w_k = r_rd_vld ? r_rd_ent.kind : rchs_pkg::KIND_EMPTY;

    assign w_ex_match = r_use_ex && (w_k == r_ex_kind) && (r_rd_ent.px == r_ex_px) &&
                        (r_rd_ent.py == r_ex_py) && (r_rd_ent.pz == r_ex_pz);
    assign w_at_end   = (r_idx == IW'(MAX_ENTRIES - 1));

    // ---------------- shared multiplier operand schedule ----------------
    always_comb begin
        w_ma    = '0;
        w_mb    = '0;
        w_first = 1'b0;
        w_neg   = 1'b0;
        w_full  = 1'b0;
        if (r_is_sph) begin
            case (r_step)
                4'd0:  begin w_ma = r_rdx; w_mb = r_rdx; w_first = 1'b1; end
                4'd1:  begin w_ma = r_rdy; w_mb = r_rdy; end
                4'd2:  begin w_ma = r_rdz; w_mb = r_rdz; end
                4'd3:  begin w_ma = r_rdx; w_mb = r_e0;  w_first = 1'b1; end
                4'd4:  begin w_ma = r_rdy; w_mb = r_e1;  end
                4'd5:  begin w_ma = r_rdz; w_mb = r_e2;  end
                4'd6:  begin w_ma = r_e0;  w_mb = r_e0;  w_first = 1'b1; end
                4'd7:  begin w_ma = r_e1;  w_mb = r_e1;  end
                4'd8:  begin w_ma = r_e2;  w_mb = r_e2;  end
                4'd9:  begin w_ma = r_rd_ent.sc; w_mb = r_rd_ent.sc; w_neg = 1'b1; end
                4'd10: begin w_ma = r_h; w_mb = r_h; w_first = 1'b1; w_full = 1'b1; end
                4'd11: begin w_ma = r_a; w_mb = r_c; w_neg = 1'b1; w_full = 1'b1; end
                default: begin end
            endcase
        end else begin
            case (r_step)
                4'd0: begin w_ma = r_rd_ent.nx; w_mb = r_rox; w_first = 1'b1; end
                4'd1: begin w_ma = r_rd_ent.ny; w_mb = r_roy; end
                4'd2: begin w_ma = r_rd_ent.nz; w_mb = r_roz; end
                4'd3: begin w_ma = r_rd_ent.nx; w_mb = r_rdx; w_first = 1'b1; end
                4'd4: begin w_ma = r_rd_ent.ny; w_mb = r_rdy; end
                4'd5: begin w_ma = r_rd_ent.nz; w_mb = r_rdz; end
                default: begin end
            endcase
        end
    end

    // Q16.16 products floor to Q16.16; the discriminant terms stay full width
    assign w_term     = w_full ? 66'(r_prod) : 66'(r_prod >>> 16);
    assign w_acc_new  = (w_first ? 66'sd0 : r_acc) + (w_neg ? -w_term : w_term);
    assign w_sat_acc  = rchs_pkg::sat32(w_acc_new);
    assign w_last     = r_is_sph ? (r_step == STP_SPH) : (r_step == STP_PLN);
    assign w_sph_miss = (r_a <= 32'sd0) || (w_acc_new < 66'sd0);
    assign w_sq_start = (r_state == S_MAC) && r_ph && r_is_sph && w_last && !w_sph_miss;

    rchs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_val   (w_acc_new[rchs_pkg::SQ_W-1:0]),
        .o_done  (w_sq_done),
        .o_root  (w_sq_root)
    );

    // ---------------- divider operands ----------------
    // sphere: (-h -/+ s) * 2^16 / a; plane: num * 2^16 / den
    assign w_nh   = -35'(r_h);
    assign w_s35  = $signed(35'(r_s));
    assign w_num1 = r_retry ? (w_nh + w_s35) : (w_nh - w_s35);
    assign w_dvd  = r_is_sph ? rchs_pkg::DIV_W'($signed({w_num1, 16'h0000}))
                             : rchs_pkg::DIV_W'($signed({r_h, 16'h0000}));
    assign w_dvs  = r_is_sph ? r_a : r_c;
    assign w_dv_start = (r_state == S_DSTART);

    rchs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_dv_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_dv_done),
        .o_quot     (w_quot)
    );

    assign w_t    = r_is_sph ? rchs_pkg::sat32(66'(w_quot)) : rchs_pkg::sat32(-66'(w_quot));
    assign w_take = (w_t > 32'sd0) && (!r_found || (w_t < r_best_t));

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_step  <= '0;
            r_ph    <= 1'b0;
            r_found <= 1'b0;
            r_retry <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_req && (i_op == rchs_pkg::OP_RAY)) begin
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        r_state <= S_EXRD;
                    end
                end
                S_EXRD: begin
                    r_state <= S_EXLAT;
                end
                S_EXLAT: begin
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (w_k == rchs_pkg::KIND_EMPTY) begin
                        r_state <= S_DONE;
                    end else if ((w_k == rchs_pkg::KIND_CAMERA) || w_ex_match) begin
                        if (w_at_end) begin
                            r_state <= S_DONE;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_RD;
                        end
                    end else if ((w_k == rchs_pkg::KIND_SPHERE) ||
                                 (w_k == rchs_pkg::KIND_PLANE)) begin
                        r_step  <= '0;
                        r_ph    <= 1'b0;
                        r_state <= S_MAC;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_MAC: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_step <= r_step + 1'b1;
                        if (w_last) begin
                            r_retry <= 1'b0;
                            if (r_is_sph ? w_sph_miss : (w_sat_acc == 32'sd0)) begin
                                if (w_at_end) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_idx   <= r_idx + 1'b1;
                                    r_state <= S_RD;
                                end
                            end else begin
                                r_state <= r_is_sph ? S_SQRT : S_DSTART;
                            end
                        end
                    end
                end
                S_SQRT: begin
                    if (w_sq_done) begin
                        r_state <= S_DSTART;
                    end
                end
                S_DSTART: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_dv_done) begin
                        // sphere: near root behind the origin, try the far root
                        if (r_is_sph && !r_retry && (w_quot < 0)) begin
                            r_retry <= 1'b1;
                            r_state <= S_DSTART;
                        end else begin
                            if (w_take) begin
                                r_found <= 1'b1;
                            end
                            if (w_at_end) begin
                                r_state <= S_DONE;
                            end else begin
                                r_idx   <= r_idx + 1'b1;
                                r_state <= S_RD;
                            end
                        end
                    end
                end
                S_DONE: begin
                    o_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_rox       <= i_px;
                r_roy       <= i_py;
                r_roz       <= i_pz;
                r_rdx       <= i_qx;
                r_rdy       <= i_qy;
                r_rdz       <= i_qz;
                r_use_ex    <= i_exclude_valid && (w_ex_ext < MAX_W);
                r_ex_idx    <= w_ex_ext[IW-1:0];
                r_best_t    <= '0;
                r_best_slot <= '0;
                r_best_kind <= rchs_pkg::KIND_EMPTY;
            end
            S_EXLAT: begin
                r_ex_kind <= w_k;
                r_ex_px   <= r_rd_ent.px;
                r_ex_py   <= r_rd_ent.py;
                r_ex_pz   <= r_rd_ent.pz;
            end
            S_CHK: begin
                r_is_sph <= (w_k == rchs_pkg::KIND_SPHERE);
                r_e0     <= rchs_pkg::sat32(66'(r_rox) - 66'(r_rd_ent.px));
                r_e1     <= rchs_pkg::sat32(66'(r_roy) - 66'(r_rd_ent.py));
                r_e2     <= rchs_pkg::sat32(66'(r_roz) - 66'(r_rd_ent.pz));
            end
            S_MAC: begin
                if (!r_ph) begin
                    r_prod <= w_ma * w_mb;
                end else begin
                    r_acc <= w_acc_new;
                    if (r_is_sph) begin
                        if (r_step == STP_A) r_a <= w_sat_acc;
                        if (r_step == STP_H) r_h <= w_sat_acc;
                        if (r_step == STP_C) r_c <= w_sat_acc;
                    end else begin
                        if (r_step == STP_NUM) begin
                            r_h <= rchs_pkg::sat32(w_acc_new + 66'(r_rd_ent.sc));
                        end
                        if (r_step == STP_PLN) r_c <= w_sat_acc;
                    end
                end
            end
            S_SQRT: begin
                if (w_sq_done) begin
                    r_s <= w_sq_root;
                end
            end
            S_DIV: begin
                if (w_dv_done && w_take && !(r_is_sph && !r_retry && (w_quot < 0))) begin
                    r_best_t    <= w_t;
                    r_best_slot <= r_idx;
                    r_best_kind <= r_rd_ent.kind;
                end
            end
            default: begin end
        endcase
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE) begin
            o_hit      <= r_found;
            o_t_value  <= r_best_t;
            o_hit_slot <= 7'(r_best_slot);
            o_hit_kind <= r_best_kind;
        end
    end

endmodule
